@@ hw/rtl/rdq_pkg.sv @@
package rdq_pkg;

    // Widths of the fixed result fields.
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned COUNT_W  = 5;

    // Operation codes carried by a command.
    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_CLEAR      = 3'd4,
        OP_LIST_FWD   = 3'd5,
        OP_LIST_REV   = 3'd6,
        OP_COUNT      = 3'd7
    } opcode_t;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        opcode_t                    opcode;
        logic signed [VALUE_W-1:0]  value;
    } cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0]        status;
        logic signed [VALUE_W-1:0]  value_res;
        logic [COUNT_W-1:0]         count;
        logic                       last;
    } result_t;

    // What every storage cell does in a given cycle.
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_TAKE_LO,
        CELL_TAKE_HI,
        CELL_LOAD,
        CELL_ROT_FWD,
        CELL_ROT_REV
    } cell_mode_t;

    typedef struct packed {
        cell_mode_t mode;
    } cell_ctrl_t;

    // Sequencer states.
    typedef enum logic {
        ST_IDLE,
        ST_LIST
    } state_t;

endpackage

@@ hw/rtl/ring_deque_engine_top.sv @@
// Double-ended queue of signed words held in a chain of storage cells.
// The front entry always sits in the first cell; every cell hands its word
// to a neighbor when entries shift or rotate.
// Command channel: a transfer happens at a rising edge with start high and
// busy low; cmd carries the opcode and the word to push.
// Result channel: strobe is high for exactly one cycle per result and the
// result is taken at the edge that ends that cycle; the receiver cannot stall.
// Push, pop, clear and count give one result in the cycle after the transfer
// and leave busy low, so one such command can follow every cycle.
// A listing of N held entries gives N results, one per cycle, starting the cycle
// after the transfer, with last set on the final one; busy is high while
// the chain keeps rotating one place per cycle.
// A listing fully rotates the chain, so the order is unchanged afterwards.
// Pops and listings on an empty queue give one empty result; a push on a
// full queue is refused with a full result.
// Reset empties the queue and drops any listing in progress; stored words
// are not cleared and are never read before being written.
module ring_deque_engine_top #(
    parameter int unsigned DEPTH      = 16,
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  rdq_pkg::cmd_t       cmd,
    output logic                strobe,
    output rdq_pkg::result_t    result
);

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam int unsigned IDX_W = $clog2(DEPTH);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    rdq_pkg::state_t        state_reg;
    rdq_pkg::state_t        state_next;
    logic [CNT_W-1:0]       cnt_reg;
    logic [CNT_W-1:0]       cnt_next;
    logic [CNT_W-1:0]       left_reg;
    logic [CNT_W-1:0]       left_next;
    logic                   rev_reg;
    logic                   rev_next;
    logic                   strobe_reg;
    logic                   strobe_next;
    rdq_pkg::result_t       result_reg;
    rdq_pkg::result_t       result_next;

    rdq_pkg::cell_ctrl_t    cell_ctrl;
    logic [DATA_WIDTH-1:0]  words [DEPTH];
    logic [DATA_WIDTH-1:0]  load_word;
    logic [DATA_WIDTH-1:0]  head_word;
    logic [DATA_WIDTH-1:0]  tail_word;
    logic [DATA_WIDTH-1:0]  chain_in;
    logic [IDX_W-1:0]       tail_idx;
    logic                   accept;
    logic                   full;
    logic                   empty;
    logic                   step_rev;

    // Stored words are sign-extended from the data width into the result field.
    function automatic logic [rdq_pkg::VALUE_W-1:0] word_out(
        input logic [DATA_WIDTH-1:0] w
    );
        return rdq_pkg::VALUE_W'(signed'(w));
    endfunction

    assign busy      = (state_reg == rdq_pkg::ST_LIST);
    assign accept    = start & ~busy;
    assign full      = (cnt_reg == CNT_FULL);
    assign empty     = (cnt_reg == '0);
    assign load_word = DATA_WIDTH'(cmd.value);
    assign tail_idx  = IDX_W'(cnt_reg - CNT_ONE);
    assign head_word = words[0];
    assign tail_word = words[tail_idx];
    assign step_rev  = busy ? rev_reg : (cmd.opcode == rdq_pkg::OP_LIST_REV);
    assign chain_in  = (cell_ctrl.mode == rdq_pkg::CELL_ROT_REV) ? tail_word : load_word;

    // Next state: a listing of more than one entry keeps the sequencer busy.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rdq_pkg::ST_IDLE:
            begin
                if (accept && !empty && cnt_reg != CNT_ONE &&
                    (cmd.opcode == rdq_pkg::OP_LIST_FWD ||
                     cmd.opcode == rdq_pkg::OP_LIST_REV))
                begin
                    state_next = rdq_pkg::ST_LIST;
                end
            end
            rdq_pkg::ST_LIST:
            begin
                if (left_reg == CNT_ONE)
                begin
                    state_next = rdq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rdq_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs: cell control, queue count and the next result.
    always_comb
    begin
        cell_ctrl.mode        = rdq_pkg::CELL_HOLD;
        cnt_next              = cnt_reg;
        left_next             = left_reg;
        rev_next              = rev_reg;
        strobe_next           = 1'b0;
        result_next.status    = rdq_pkg::STATUS_OK;
        result_next.value_res = '0;
        result_next.count     = rdq_pkg::COUNT_W'(cnt_reg);
        result_next.last      = 1'b1;

        unique case (state_reg)
            rdq_pkg::ST_LIST:
            begin
                cell_ctrl.mode        = rev_reg ? rdq_pkg::CELL_ROT_REV : rdq_pkg::CELL_ROT_FWD;
                result_next.value_res = word_out(step_rev ? tail_word : head_word);
                result_next.last      = (left_reg == CNT_ONE);
                left_next             = left_reg - CNT_ONE;
                strobe_next           = 1'b1;
            end
            rdq_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    strobe_next = 1'b1;
                    unique case (cmd.opcode)
                        rdq_pkg::OP_PUSH_FRONT, rdq_pkg::OP_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                result_next.status = rdq_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                cell_ctrl.mode = (cmd.opcode == rdq_pkg::OP_PUSH_FRONT) ?
                                                 rdq_pkg::CELL_TAKE_LO : rdq_pkg::CELL_LOAD;
                                cnt_next          = cnt_reg + CNT_ONE;
                                result_next.count = rdq_pkg::COUNT_W'(cnt_reg + CNT_ONE);
                            end
                        end
                        rdq_pkg::OP_POP_FRONT, rdq_pkg::OP_POP_BACK:
                        begin
                            if (empty)
                            begin
                                result_next.status = rdq_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                if (cmd.opcode == rdq_pkg::OP_POP_FRONT)
                                begin
                                    cell_ctrl.mode        = rdq_pkg::CELL_TAKE_HI;
                                    result_next.value_res = word_out(head_word);
                                end
                                else
                                begin
                                    result_next.value_res = word_out(tail_word);
                                end
                                cnt_next          = cnt_reg - CNT_ONE;
                                result_next.count = rdq_pkg::COUNT_W'(cnt_reg - CNT_ONE);
                            end
                        end
                        rdq_pkg::OP_CLEAR:
                        begin
                            cnt_next          = '0;
                            result_next.count = '0;
                        end
                        rdq_pkg::OP_LIST_FWD, rdq_pkg::OP_LIST_REV:
                        begin
                            if (empty)
                            begin
                                result_next.status = rdq_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                // The first entry goes out with the transfer itself.
                                cell_ctrl.mode        = step_rev ? rdq_pkg::CELL_ROT_REV :
                                                                   rdq_pkg::CELL_ROT_FWD;
                                result_next.value_res = word_out(step_rev ? tail_word : head_word);
                                result_next.last      = (cnt_reg == CNT_ONE);
                                left_next             = cnt_reg - CNT_ONE;
                                rev_next              = step_rev;
                            end
                        end
                        rdq_pkg::OP_COUNT:
                        begin
                            result_next.status = rdq_pkg::STATUS_OK;
                        end
                        default:
                        begin
                            result_next.status = rdq_pkg::STATUS_OK;
                        end
                    endcase
                end
            end
            default:
            begin
                cell_ctrl.mode = rdq_pkg::CELL_HOLD;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= rdq_pkg::ST_IDLE;
            cnt_reg    <= '0;
            left_reg   <= '0;
            rev_reg    <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            left_reg   <= left_next;
            rev_reg    <= rev_next;
            strobe_reg <= strobe_next;
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

    // The chain of storage cells; cell 0 holds the front entry.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] lo_w;
        logic [DATA_WIDTH-1:0] hi_w;

        if (i == 0)
        begin : g_first
            assign lo_w = chain_in;
        end
        else
        begin : g_mid_lo
            assign lo_w = words[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign hi_w = words[i];
        end
        else
        begin : g_mid_hi
            assign hi_w = words[i+1];
        end

        rdq_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .CNT_W      (CNT_W),
            .IDX        (i)
        ) u_cell (
            .clk       (clk),
            .ctrl      (cell_ctrl),
            .cnt       (cnt_reg),
            .load_word (load_word),
            .wrap_word (head_word),
            .lo_word   (lo_w),
            .hi_word   (hi_w),
            .word      (words[i])
        );
    end

endmodule

@@ hw/rtl/rdq_cell.sv @@
module rdq_cell #(
    parameter int unsigned DATA_WIDTH = 32,
    parameter int unsigned CNT_W      = 5,
    parameter int unsigned IDX        = 0
) (
    input  logic                    clk,
    input  rdq_pkg::cell_ctrl_t     ctrl,
    input  logic [CNT_W-1:0]        cnt,
    input  logic [DATA_WIDTH-1:0]   load_word,
    input  logic [DATA_WIDTH-1:0]   wrap_word,
    input  logic [DATA_WIDTH-1:0]   lo_word,
    input  logic [DATA_WIDTH-1:0]   hi_word,
    output logic [DATA_WIDTH-1:0]   word
);

    localparam logic [CNT_W-1:0] POS      = CNT_W'(IDX);
    localparam logic [CNT_W-1:0] POS_NEXT = CNT_W'(IDX + 1);

    logic [DATA_WIDTH-1:0] word_reg;
    logic [DATA_WIDTH-1:0] word_next;

    // Pick the new content from the neighbors, the load word or the wrap word.
    always_comb
    begin
        word_next = word_reg;
        unique case (ctrl.mode)
            rdq_pkg::CELL_HOLD:
            begin
                word_next = word_reg;
            end
            rdq_pkg::CELL_TAKE_LO:
            begin
                word_next = lo_word;
            end
            rdq_pkg::CELL_TAKE_HI:
            begin
                word_next = hi_word;
            end
            rdq_pkg::CELL_LOAD:
            begin
                if (POS == cnt)
                begin
                    word_next = load_word;
                end
            end
            rdq_pkg::CELL_ROT_FWD:
            begin
                // Held entries move one place toward the front; the front wraps to the tail.
                if (POS_NEXT < cnt)
                begin
                    word_next = hi_word;
                end
                else if (POS_NEXT == cnt)
                begin
                    word_next = wrap_word;
                end
            end
            rdq_pkg::CELL_ROT_REV:
            begin
                // Held entries move one place toward the back; the tail enters at the front.
                if (POS < cnt)
                begin
                    word_next = lo_word;
                end
            end
            default:
            begin
                word_next = word_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule
